>>> hw/rtl/twsi_pkg.sv
// types and codes shared by the three-way sorted intersection block
`timescale 1ns / 1ps
`default_nettype none

package twsi_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_LOAD_C = 2'd2,
      OP_START  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] common_value;
      logic               found;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage

`default_nettype wire

>>> hw/rtl/twsi_cmp.sv
// shared signed compare unit used for every step of the walk
`timescale 1ns / 1ps
`default_nettype none

module twsi_cmp
   import twsi_pkg::*;
(
   input  wire logic signed [31:0] x,
   input  wire logic signed [31:0] y,
   output cmp_res_type             res
);

   always_comb begin
      res.lt = (x < y);
      res.eq = (x == y);
   end

endmodule

`default_nettype wire

>>> hw/rtl/three_way_sorted_intersection.sv
// three-way sorted intersection: load beats are accepted back to back while the block is idle.
// a start beat walks the lists with one shared compare unit: each walk step passes through
// a memory read, a compare of a with b and a compare of c with the smaller, and each common
// value adds an emit state that waits for a free output slot; results leave through one output register.
// reset (synchronous, active high) clears counts, sequencer and output valid;
// list memories are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module three_way_sorted_intersection
   import twsi_pkg::*;
#(
   parameter int LIST_DEPTH = 64
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_CMP_AB = 6'b000100,
      ST_CMP_C  = 6'b001000,
      ST_EMIT   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   logic signed [31:0] mem_a [LIST_DEPTH];
   logic signed [31:0] mem_b [LIST_DEPTH];
   logic signed [31:0] mem_c [LIST_DEPTH];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in, cnt_c_ff, cnt_c_in;
   logic [CNT_W-1:0]   idx_a_ff, idx_a_in, idx_b_ff, idx_b_in, idx_c_ff, idx_c_in;
   logic signed [31:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic signed [31:0] lo_ab_ff, lo_ab_in;
   logic               a_lt_b_ff, a_lt_b_in, b_lt_a_ff, b_lt_a_in;
   logic signed [31:0] pend_ff, pend_in;
   logic               have_pend_ff, have_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_beat;
   logic               slot_free;
   logic               load_a, load_b, load_c;
   logic signed [31:0] cmp_x, cmp_y;
   cmp_res_type        cmp_res;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign load_a = req_beat && (req_data.operation == OP_LOAD_A) && (cnt_a_ff < DEPTH_C);
   assign load_b = req_beat && (req_data.operation == OP_LOAD_B) && (cnt_b_ff < DEPTH_C);
   assign load_c = req_beat && (req_data.operation == OP_LOAD_C) && (cnt_c_ff < DEPTH_C);

   // operand select for the shared compare unit
   always_comb begin
      if (state_ff == ST_CMP_C) begin
         cmp_x = rd_c_ff;
         cmp_y = lo_ab_ff;
      end else begin
         cmp_x = rd_a_ff;
         cmp_y = rd_b_ff;
      end
   end

   twsi_cmp u_cmp (
      .x   (cmp_x),
      .y   (cmp_y),
      .res (cmp_res)
   );

   always_ff @(posedge clock) begin
      if (load_a) begin
         mem_a[cnt_a_ff[IDX_W-1:0]] <= req_data.value;
      end
      if (load_b) begin
         mem_b[cnt_b_ff[IDX_W-1:0]] <= req_data.value;
      end
      if (load_c) begin
         mem_c[cnt_c_ff[IDX_W-1:0]] <= req_data.value;
      end
      rd_a_ff <= mem_a[idx_a_ff[IDX_W-1:0]];
      rd_b_ff <= mem_b[idx_b_ff[IDX_W-1:0]];
      rd_c_ff <= mem_c[idx_c_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      cnt_c_in     = cnt_c_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      idx_c_in     = idx_c_ff;
      lo_ab_in     = lo_ab_ff;
      a_lt_b_in    = a_lt_b_ff;
      b_lt_a_in    = b_lt_a_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (load_a) begin
               cnt_a_in = cnt_a_ff + ONE_C;
            end
            if (load_b) begin
               cnt_b_in = cnt_b_ff + ONE_C;
            end
            if (load_c) begin
               cnt_c_in = cnt_c_ff + ONE_C;
            end
            if (req_beat && (req_data.operation == OP_START)) begin
               idx_a_in     = '0;
               idx_b_in     = '0;
               idx_c_in     = '0;
               have_pend_in = 1'b0;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((idx_a_ff < cnt_a_ff) && (idx_b_ff < cnt_b_ff) && (idx_c_ff < cnt_c_ff)) begin
               state_in = ST_CMP_AB;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CMP_AB: begin
            a_lt_b_in = cmp_res.lt;
            b_lt_a_in = !cmp_res.lt && !cmp_res.eq;
            lo_ab_in  = cmp_res.lt ? rd_a_ff : rd_b_ff;
            state_in  = ST_CMP_C;
         end
         ST_CMP_C: begin
            if (!a_lt_b_ff && !b_lt_a_ff && cmp_res.eq) begin
               state_in = ST_EMIT;
            end else begin
               // advance every list sitting on the minimum
               if (!cmp_res.lt && !b_lt_a_ff) begin
                  idx_a_in = idx_a_ff + ONE_C;
               end
               if (!cmp_res.lt && !a_lt_b_ff) begin
                  idx_b_in = idx_b_ff + ONE_C;
               end
               if (cmp_res.lt || cmp_res.eq) begin
                  idx_c_in = idx_c_ff + ONE_C;
               end
               state_in = ST_CHECK;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (have_pend_ff) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.common_value = pend_ff;
                  rsp_data_in.found        = 1'b1;
                  rsp_data_in.last         = 1'b0;
               end
               pend_in      = rd_a_ff;
               have_pend_in = 1'b1;
               idx_a_in     = idx_a_ff + ONE_C;
               idx_b_in     = idx_b_ff + ONE_C;
               idx_c_in     = idx_c_ff + ONE_C;
               state_in     = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in.last = 1'b1;
               if (have_pend_ff) begin
                  rsp_data_in.common_value = pend_ff;
                  rsp_data_in.found        = 1'b1;
               end else begin
                  rsp_data_in.common_value = '0;
                  rsp_data_in.found        = 1'b0;
               end
               have_pend_in = 1'b0;
               cnt_a_in     = '0;
               cnt_b_in     = '0;
               cnt_c_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         cnt_c_ff     <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         cnt_c_ff     <= cnt_c_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_a_ff    <= idx_a_in;
      idx_b_ff    <= idx_b_in;
      idx_c_ff    <= idx_c_in;
      lo_ab_ff    <= lo_ab_in;
      a_lt_b_ff   <= a_lt_b_in;
      b_lt_a_ff   <= b_lt_a_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
